@@ rtl/b3h_pkg.sv @@
package b3h_pkg;

  localparam int unsigned StackDepthDefault = 54;
  localparam int unsigned BytesPerItemDefault = 8;

  localparam logic [31:0] FlagStart  = 32'h01;
  localparam logic [31:0] FlagEnd    = 32'h02;
  localparam logic [31:0] FlagParent = 32'h04;
  localparam logic [31:0] FlagRoot   = 32'h08;

  localparam logic [31:0] IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [3:0] WordOrder [16] = '{
    4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
    4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8
  };

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    CmdNone,
    CmdLoadByte,    // write one byte of the held item into the buffer
    CmdStartBlock,  // start compression of the buffered block
    CmdStartParent, // start parent compression of stack top and cv
    CmdRound,       // run one half round
    CmdBlockDone,   // fold result into chain value, clear buffer
    CmdLeafDone,    // take leaf cv into the working cv
    CmdParentDone,  // take parent result into the working cv
    CmdPush,        // write working cv onto the stack
    CmdStackRead,   // read the stack top into the left register
    CmdNewMsg       // return to reset state
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] extra_flags;
  } ctrl_t;

  typedef struct packed {
    logic       round_last;
    logic [6:0] block_fill;
    logic [4:0] blocks_done;
    logic       idx_bit;
    logic [5:0] stack_count;
  } stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ rtl/blake3_stream_hasher.sv @@
// BLAKE3 unkeyed 256-bit hasher. Each input word carries up to eight message
// bytes (first byte in bits 7:0) and a byte count; the word with
// end_of_message set closes the message, after which the 32-byte digest
// leaves as four 64-bit words, word_index 0 to 3, last_word on the fourth.
// Input is stalled while a word is processed: bytes load one per cycle while
// no compression runs, a 64-byte block compression runs its half rounds on
// the single half-round unit, and each subtree merge adds a parent compression
// on the same unit after a registered stack memory read. A word that crosses
// a block or a chunk takes longer, as it waits for those compressions.
// After the digest has been taken the block is back in its reset state.
module blake3_stream_hasher #(
  parameter int unsigned STACK_DEPTH    = b3h_pkg::StackDepthDefault,
  parameter int unsigned BYTES_PER_ITEM = b3h_pkg::BytesPerItemDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] data_bytes_i,
  input  logic [3:0]  byte_count_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] digest_word_o,
  output logic [1:0]  word_index_o,
  output logic        last_word_o
);
  import b3h_pkg::*;

  ctrl_t        ctrl;
  stat_t        stat;
  logic [7:0]   byte_w;
  logic [255:0] hash_w;

  b3h_ctrl #(.BYTES_PER_ITEM(BYTES_PER_ITEM)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_bytes_i, .byte_count_i,
    .end_of_message_i, .stat_i(stat), .ctrl_o(ctrl), .byte_o(byte_w),
    .hash_i(hash_w), .out_valid_o, .out_stall_i, .digest_word_o,
    .word_index_o, .last_word_o
  );

  b3h_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .byte_i(byte_w), .stat_o(stat), .hash_o(hash_w)
  );

endmodule

@@ rtl/b3h_datapath.sv @@
module b3h_datapath #(
  parameter int unsigned STACK_DEPTH = 54
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  b3h_pkg::ctrl_t  ctrl_i,
  input  logic [7:0]      byte_i,
  output b3h_pkg::stat_t  stat_o,
  output logic [255:0]    hash_o
);
  import b3h_pkg::*;

  localparam int unsigned SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // The block buffer is held as sixteen little-endian message words.
  logic [31:0]  buf_q [16];
  logic [6:0]   fill_q;
  logic [4:0]   done_q;
  logic [63:0]  cidx_q;
  logic [63:0]  idx_shift_q;
  logic [5:0]   cnt_q;
  logic [31:0]  cv_q [8];
  logic [31:0]  work_q [8];
  logic [31:0]  left_q [8];
  logic [31:0]  v_q [16];
  logic [31:0]  m_q [16];
  logic [3:0]   step_q;
  logic [255:0] stack_mem [STACK_DEPTH];
  logic [255:0] rd_q;

  logic [31:0] v_d [16];
  logic [31:0] m_perm [16];
  logic [SW-1:0] top_addr;
  logic [SW-1:0] push_addr;

  // One half round: four independent G functions on columns or diagonals.
  always_comb begin
    logic [31:0] t [16];
    logic [3:0] ai, bi, ci, di;
    int g;
    for (int i = 0; i < 16; i++) t[i] = v_q[i];
    for (g = 0; g < 4; g++) begin
      ai = 4'(g);
      if (!step_q[0]) begin
        bi = 4'(g + 4); ci = 4'(g + 8); di = 4'(g + 12);
      end else begin
        bi = 4'(4 + ((g + 1) % 4)); ci = 4'(8 + ((g + 2) % 4));
        di = 4'(12 + ((g + 3) % 4));
      end
      t[ai] = t[ai] + t[bi] + m_q[step_q[0] ? 8 + 2 * g : 2 * g];
      t[di] = rotr(t[di] ^ t[ai], 16);
      t[ci] = t[ci] + t[di];
      t[bi] = rotr(t[bi] ^ t[ci], 12);
      t[ai] = t[ai] + t[bi] + m_q[step_q[0] ? 9 + 2 * g : 2 * g + 1];
      t[di] = rotr(t[di] ^ t[ai], 8);
      t[ci] = t[ci] + t[di];
      t[bi] = rotr(t[bi] ^ t[ci], 7);
    end
    for (int i = 0; i < 16; i++) v_d[i] = t[i];
    for (int i = 0; i < 16; i++) m_perm[i] = m_q[WordOrder[i]];
  end

  assign top_addr  = SW'((cnt_q == 6'd0) ? 6'd0 : cnt_q - 6'd1);
  assign push_addr = SW'((cnt_q >= 6'(STACK_DEPTH)) ? 6'(STACK_DEPTH - 1) : cnt_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == CmdPush) stack_mem[push_addr] <= {work_q[7], work_q[6], work_q[5],
      work_q[4], work_q[3], work_q[2], work_q[1], work_q[0]};
    rd_q <= stack_mem[top_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0; done_q <= '0; cidx_q <= '0; cnt_q <= '0; step_q <= '0;
      idx_shift_q <= '0;
      for (int i = 0; i < 16; i++) buf_q[i] <= '0;
      for (int i = 0; i < 8; i++) cv_q[i] <= IV[i];
    end else begin
      case (ctrl_i.cmd)
        CmdLoadByte: begin
          buf_q[fill_q[5:2]][{fill_q[1:0], 3'b000} +: 8] <= byte_i;
          fill_q <= fill_q + 7'd1;
        end
        CmdStartBlock: begin
          for (int i = 0; i < 8; i++) v_q[i] <= cv_q[i];
          for (int i = 0; i < 4; i++) v_q[8 + i] <= IV[i];
          v_q[12] <= cidx_q[31:0];
          v_q[13] <= cidx_q[63:32];
          v_q[14] <= {25'd0, fill_q};
          v_q[15] <= ctrl_i.extra_flags | ((done_q == 5'd0) ? FlagStart : 32'd0);
          for (int i = 0; i < 16; i++) m_q[i] <= buf_q[i];
          step_q <= '0;
        end
        CmdStartParent: begin
          for (int i = 0; i < 8; i++) begin
            v_q[i] <= IV[i];
            m_q[i] <= left_q[i]; m_q[8 + i] <= work_q[i];
          end
          for (int i = 0; i < 4; i++) v_q[8 + i] <= IV[i];
          v_q[12] <= '0; v_q[13] <= '0; v_q[14] <= 32'd64;
          v_q[15] <= FlagParent | ctrl_i.extra_flags;
          step_q <= '0;
        end
        CmdRound: begin
          for (int i = 0; i < 16; i++) v_q[i] <= v_d[i];
          if (step_q[0]) for (int i = 0; i < 16; i++) m_q[i] <= m_perm[i];
          step_q <= step_q + 4'd1;
        end
        CmdBlockDone: begin
          for (int i = 0; i < 8; i++) cv_q[i] <= v_q[i] ^ v_q[8 + i];
          for (int i = 0; i < 16; i++) buf_q[i] <= '0;
          done_q <= done_q + 5'd1;
          fill_q <= '0;
        end
        CmdLeafDone: begin
          for (int i = 0; i < 8; i++) work_q[i] <= v_q[i] ^ v_q[8 + i];
          idx_shift_q <= cidx_q;
        end
        CmdParentDone: begin
          for (int i = 0; i < 8; i++) work_q[i] <= v_q[i] ^ v_q[8 + i];
          idx_shift_q <= idx_shift_q >> 1;
          cnt_q <= cnt_q - 6'd1;
        end
        CmdStackRead: begin
          for (int i = 0; i < 8; i++) left_q[i] <= rd_q[32*i +: 32];
        end
        CmdPush: begin
          if (cnt_q < 6'(STACK_DEPTH)) cnt_q <= cnt_q + 6'd1;
          cidx_q <= cidx_q + 64'd1;
          for (int i = 0; i < 16; i++) buf_q[i] <= '0;
          for (int i = 0; i < 8; i++) cv_q[i] <= IV[i];
          fill_q <= '0; done_q <= '0;
        end
        CmdNewMsg: begin
          for (int i = 0; i < 16; i++) buf_q[i] <= '0;
          for (int i = 0; i < 8; i++) cv_q[i] <= IV[i];
          fill_q <= '0; done_q <= '0; cidx_q <= '0; cnt_q <= '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) hash_o[32*i +: 32] = v_q[i] ^ v_q[8 + i];
  end

  assign stat_o.round_last  = (step_q == 4'd13);
  assign stat_o.block_fill  = fill_q;
  assign stat_o.blocks_done = done_q;
  assign stat_o.idx_bit     = idx_shift_q[0];
  assign stat_o.stack_count = cnt_q;

endmodule

@@ rtl/b3h_ctrl.sv @@
module b3h_ctrl #(
  parameter int unsigned BYTES_PER_ITEM = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [63:0]    data_bytes_i,
  input  logic [3:0]     byte_count_i,
  input  logic           end_of_message_i,
  input  b3h_pkg::stat_t stat_i,
  output b3h_pkg::ctrl_t ctrl_o,
  output logic [7:0]     byte_o,
  input  logic [255:0]   hash_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [63:0]    digest_word_o,
  output logic [1:0]     word_index_o,
  output logic           last_word_o
);
  import b3h_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_BYTE   = 4'd1;
  localparam logic [3:0] S_BLK    = 4'd2;
  localparam logic [3:0] S_LEAF   = 4'd3;
  localparam logic [3:0] S_MRD    = 4'd4;
  localparam logic [3:0] S_MLD    = 4'd5;
  localparam logic [3:0] S_MPAR   = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;
  localparam logic [3:0] S_FRD    = 4'd8;
  localparam logic [3:0] S_FLD    = 4'd9;
  localparam logic [3:0] S_FPAR   = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;
  localparam logic [3:0] S_RUN    = 4'd12;

  localparam logic [3:0] CntMax = 4'(BYTES_PER_ITEM);

  logic [3:0]   state_q, state_d, ret_q, ret_d;
  logic [63:0]  data_q;
  logic [3:0]   left_q, left_d;
  logic         eom_q;
  logic [255:0] dig_q;
  logic [1:0]   widx_q;
  logic         root_q, root_d;
  logic         accept;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign byte_o = data_q[7:0];

  always_comb begin
    state_d = state_q; ret_d = ret_q; left_d = left_q; root_d = root_q;
    ctrl_o.cmd = CmdNone; ctrl_o.extra_flags = '0;
    case (state_q)
      S_IDLE: if (accept) begin
        left_d = (byte_count_i > CntMax) ? CntMax : byte_count_i;
        state_d = S_BYTE;
      end
      S_BYTE: begin
        if (left_q == 4'd0) state_d = eom_q ? S_FIN : S_IDLE;
        else if (stat_i.block_fill < 7'd64) begin
          ctrl_o.cmd = CmdLoadByte; left_d = left_q - 4'd1;
        end else if (stat_i.blocks_done >= 5'd15) begin
          ctrl_o.cmd = CmdStartBlock; ctrl_o.extra_flags = FlagEnd;
          state_d = S_RUN; ret_d = S_LEAF;
        end else begin
          ctrl_o.cmd = CmdStartBlock; state_d = S_RUN; ret_d = S_BLK;
        end
      end
      S_RUN: begin
        ctrl_o.cmd = CmdRound;
        if (stat_i.round_last) state_d = ret_q;
      end
      S_BLK: begin ctrl_o.cmd = CmdBlockDone; state_d = S_BYTE; end
      S_LEAF: begin ctrl_o.cmd = CmdLeafDone; state_d = S_MRD; end
      S_MRD: begin
        // The leaf index is loaded; merge while its low bit is one and the stack is not empty.
        if (stat_i.idx_bit && stat_i.stack_count != 6'd0) state_d = S_MLD;
        else begin ctrl_o.cmd = CmdPush; state_d = S_BYTE; end
      end
      S_MLD: begin ctrl_o.cmd = CmdStackRead; state_d = S_MPAR; end
      S_MPAR: begin
        ctrl_o.cmd = CmdStartParent; state_d = S_RUN; ret_d = S_FPAR; root_d = 1'b0;
      end
      S_FIN: begin
        ctrl_o.cmd = CmdStartBlock;
        ctrl_o.extra_flags = (stat_i.stack_count == 6'd0) ? (FlagEnd | FlagRoot) : FlagEnd;
        root_d = (stat_i.stack_count == 6'd0);
        state_d = S_RUN; ret_d = S_FLD;
      end
      S_FLD: begin
        if (root_q) state_d = S_OUT;
        else begin ctrl_o.cmd = CmdLeafDone; state_d = S_FRD; end
      end
      S_FRD: begin
        if (stat_i.stack_count == 6'd0) state_d = S_OUT;
        else begin ctrl_o.cmd = CmdStackRead; state_d = S_FPAR; ret_d = S_FLD; end
      end
      S_FPAR: begin
        if (ret_q == S_FPAR) begin
          // A merge parent has finished.
          ctrl_o.cmd = CmdParentDone; state_d = S_MRD;
        end else if (ret_q == S_FLD) begin
          ctrl_o.cmd = CmdStartParent;
          ctrl_o.extra_flags = (stat_i.stack_count == 6'd1) ? FlagRoot : 32'd0;
          root_d = (stat_i.stack_count == 6'd1);
          state_d = S_RUN; ret_d = S_IDLE;
        end else if (ret_q == S_IDLE) begin
          if (root_q) state_d = S_OUT;
          else begin
            // The stack count drops here; passing through S_FLD lets the registered
            // stack read follow the new top before S_FRD takes it.
            ctrl_o.cmd = CmdParentDone; state_d = S_FLD;
          end
        end else state_d = S_FRD;
      end
      S_OUT: if (out_valid_o && !out_stall_i && widx_q == 2'd3) begin
        ctrl_o.cmd = CmdNewMsg; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // Final parent returns to S_FPAR with ret S_IDLE; route run exits there.
    if (state_q == S_RUN && stat_i.round_last && ret_q == S_IDLE) state_d = S_FPAR;
    if (state_q == S_RUN && stat_i.round_last && ret_q == S_FPAR) state_d = S_FPAR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ret_q <= S_IDLE; left_q <= '0; eom_q <= 1'b0;
      root_q <= 1'b0; widx_q <= '0; out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d; ret_q <= ret_d; left_q <= left_d; root_q <= root_d;
      if (accept) eom_q <= end_of_message_i;
      if (state_q != S_OUT && state_d == S_OUT) begin
        out_valid_o <= 1'b1; widx_q <= '0;
      end else if (out_valid_o && !out_stall_i) begin
        widx_q <= widx_q + 2'd1;
        if (widx_q == 2'd3) out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) data_q <= data_bytes_i;
    else if (ctrl_o.cmd == CmdLoadByte) data_q <= data_q >> 8;
    if (state_q != S_OUT && state_d == S_OUT) dig_q <= hash_i;
  end

  assign digest_word_o = dig_q[64*widx_q +: 64];
  assign word_index_o  = widx_q;
  assign last_word_o   = (widx_q == 2'd3);

endmodule

@@ dv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // The hasher is driven with message words of up to eight bytes. A model of
  // BLAKE3 in plain hash mode runs beside it and predicts the four digest
  // words that follow each end-of-message word. Every digest word the block
  // hands out is compared field by field with the oldest prediction.

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] data_bytes_i;
  logic [3:0]  byte_count_i;
  logic        end_of_message_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] digest_word_o;
  logic [1:0]  word_index_o;
  logic        last_word_o;

  blake3_stream_hasher i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_bytes_i     (data_bytes_i),
    .byte_count_i     (byte_count_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .digest_word_o    (digest_word_o),
    .word_index_o     (word_index_o),
    .last_word_o      (last_word_o)
  );

  localparam int unsigned StackDepth = b3h_pkg::StackDepthDefault;
  localparam int unsigned MaxBytes   = b3h_pkg::BytesPerItemDefault;

  typedef struct {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  typedef logic [31:0] cv_t [8];
  typedef logic [31:0] blk_t [16];

  // Model state of the hasher.
  cv_t         chain_cv;
  logic [7:0]  blk_bytes [64];
  int unsigned blk_fill;
  int unsigned blk_count;
  logic [63:0] chunk_ctr;
  logic [31:0] node_stack [StackDepth][8];
  int unsigned cv_depth;

  digest_beat_t pending_digest [$];
  int unsigned  err_count;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Runs far beyond the slowest legal run; a hang ends here.
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void g_mix(ref logic [31:0] v [16], input int a, input int b,
                                input int c, input int d, input logic [31:0] x,
                                input logic [31:0] y);
    v[a] = v[a] + v[b] + x;
    v[d] = ror32(v[d] ^ v[a], 16);
    v[c] = v[c] + v[d];
    v[b] = ror32(v[b] ^ v[c], 12);
    v[a] = v[a] + v[b] + y;
    v[d] = ror32(v[d] ^ v[a], 8);
    v[c] = v[c] + v[d];
    v[b] = ror32(v[b] ^ v[c], 7);
  endfunction

  // Full BLAKE3 compression; returns all sixteen output words.
  function automatic blk_t compress_block(cv_t cv, blk_t msg, logic [63:0] ctr,
                                          logic [31:0] len, logic [31:0] flags);
    logic [31:0] v [16];
    logic [31:0] m [16];
    blk_t        t;
    for (int i = 0; i < 8; i++) v[i] = cv[i];
    for (int i = 0; i < 4; i++) v[8 + i] = b3h_pkg::IV[i];
    v[12] = ctr[31:0];
    v[13] = ctr[63:32];
    v[14] = len;
    v[15] = flags;
    for (int i = 0; i < 16; i++) m[i] = msg[i];
    for (int r = 0; r < 7; r++) begin
      g_mix(v, 0, 4, 8, 12, m[0], m[1]);
      g_mix(v, 1, 5, 9, 13, m[2], m[3]);
      g_mix(v, 2, 6, 10, 14, m[4], m[5]);
      g_mix(v, 3, 7, 11, 15, m[6], m[7]);
      g_mix(v, 0, 5, 10, 15, m[8], m[9]);
      g_mix(v, 1, 6, 11, 12, m[10], m[11]);
      g_mix(v, 2, 7, 8, 13, m[12], m[13]);
      g_mix(v, 3, 4, 9, 14, m[14], m[15]);
      for (int i = 0; i < 16; i++) t[i] = m[b3h_pkg::WordOrder[i]];
      for (int i = 0; i < 16; i++) m[i] = t[i];
    end
    for (int i = 0; i < 8; i++) begin
      t[i]     = v[i] ^ v[i + 8];
      t[i + 8] = v[i + 8] ^ cv[i];
    end
    return t;
  endfunction

  function automatic blk_t compress_chunk_block(logic [31:0] extra);
    blk_t w;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i+3], blk_bytes[4*i+2], blk_bytes[4*i+1], blk_bytes[4*i]};
    if (blk_count == 0) extra = extra | b3h_pkg::FlagStart;
    return compress_block(chain_cv, w, chunk_ctr, blk_fill, extra);
  endfunction

  function automatic blk_t compress_parent(int unsigned slot, cv_t right,
                                           logic [31:0] extra);
    blk_t w;
    cv_t  ivc;
    for (int i = 0; i < 8; i++) begin
      w[i]     = node_stack[slot][i];
      w[i + 8] = right[i];
      ivc[i]   = b3h_pkg::IV[i];
    end
    return compress_block(ivc, w, 64'd0, 32'd64, b3h_pkg::FlagParent | extra);
  endfunction

  function automatic void open_chunk();
    for (int i = 0; i < 8; i++) chain_cv[i] = b3h_pkg::IV[i];
    for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
    blk_fill  = 0;
    blk_count = 0;
  endfunction

  function automatic void hasher_reset();
    open_chunk();
    chunk_ctr = 64'd0;
    cv_depth  = 0;
  endfunction

  function automatic void close_leaf();
    blk_t        o;
    cv_t         cv;
    logic [63:0] idx;
    idx = chunk_ctr;
    o = compress_chunk_block(b3h_pkg::FlagEnd);
    for (int i = 0; i < 8; i++) cv[i] = o[i];
    // One merge per trailing one of the chunk index.
    while (idx[0] && cv_depth > 0) begin
      cv_depth--;
      o = compress_parent(cv_depth, cv, 32'd0);
      for (int i = 0; i < 8; i++) cv[i] = o[i];
      idx = idx >> 1;
    end
    if (cv_depth >= StackDepth) cv_depth = StackDepth - 1;
    for (int i = 0; i < 8; i++) node_stack[cv_depth][i] = cv[i];
    cv_depth++;
    chunk_ctr++;
    open_chunk();
  endfunction

  function automatic void absorb_byte(logic [7:0] b);
    blk_t o;
    // A full block is only compressed once another byte shows up.
    if (blk_fill >= 64) begin
      if (blk_count >= 15) begin
        close_leaf();
      end else begin
        o = compress_chunk_block(32'd0);
        for (int i = 0; i < 8; i++) chain_cv[i] = o[i];
        blk_count++;
        blk_fill = 0;
        for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
      end
    end
    blk_bytes[blk_fill % 64] = b;
    blk_fill++;
  endfunction

  // Advances the model by one word and, on an end-of-message word, queues the digest it produces.
  function automatic void hash_word(logic [63:0] data, logic [3:0] cnt, logic eom);
    blk_t         o;
    cv_t          cv;
    int unsigned  n;
    digest_beat_t beat;
    n = (cnt > MaxBytes) ? MaxBytes : cnt;
    for (int k = 0; k < n; k++) absorb_byte(data[8*k +: 8]);
    if (!eom) return;
    if (cv_depth == 0) begin
      o = compress_chunk_block(b3h_pkg::FlagEnd | b3h_pkg::FlagRoot);
    end else begin
      o = compress_chunk_block(b3h_pkg::FlagEnd);
      for (int i = 0; i < 8; i++) cv[i] = o[i];
      while (cv_depth > 1) begin
        cv_depth--;
        o = compress_parent(cv_depth, cv, 32'd0);
        for (int i = 0; i < 8; i++) cv[i] = o[i];
      end
      o = compress_parent(0, cv, b3h_pkg::FlagRoot);
    end
    for (int k = 0; k < 4; k++) begin
      beat.digest_word = {o[2*k+1], o[2*k]};
      beat.word_index  = 2'(k);
      beat.last_word   = (k == 3);
      pending_digest.push_back(beat);
    end
    hasher_reset();
  endfunction

  // Sends one word and waits for it to be taken; the model follows on accept.
  // Valid stays up after the accept until the next word or an idle cycle.
  task automatic send_word(logic [63:0] data, logic [3:0] cnt, logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    data_bytes_i     <= data;
    byte_count_i     <= cnt;
    end_of_message_i <= eom;
    do @(posedge clk_i); while (in_stall_o);
    hash_word(data, cnt, eom);
  endtask

  // Sends a message of up to the given length in words of random size (oversized counts cut it short).
  task automatic send_message(int unsigned len);
    int unsigned left;
    int unsigned n;
    left = len;
    while (left > 0) begin
      n = $urandom_range(1, MaxBytes);
      if (n > left) n = left;
      if ($urandom_range(19) == 0) n = $urandom_range(9, 15);  // oversized count
      left = (n >= left) ? 0 : left - n;
      send_word({$urandom, $urandom}, 4'(n), left == 0);
    end
    if (len == 0) send_word({$urandom, $urandom}, 4'd0, 1'b1);
  endtask

  task automatic drain_digests();
    in_valid_i <= 1'b0;
    while (pending_digest.size() != 0) @(posedge clk_i);
  endtask

  // Random stall on the digest side.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compares each digest word the block hands over with the oldest prediction.
  always @(posedge clk_i) begin
    digest_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_digest.size() == 0) begin
        $error("unexpected digest word %h", digest_word_o);
        err_count++;
      end else begin
        want = pending_digest.pop_front();
        if (digest_word_o !== want.digest_word) begin
          $error("digest_word expected %h actual %h", want.digest_word, digest_word_o);
          err_count++;
        end
        if (word_index_o !== want.word_index) begin
          $error("word_index expected %0d actual %0d", want.word_index, word_index_o);
          err_count++;
        end
        if (last_word_o !== want.last_word) begin
          $error("last_word expected %0d actual %0d", want.last_word, last_word_o);
          err_count++;
        end
      end
    end
  end

  typedef struct {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        eom;
    logic [63:0] dig0;  // first digest word where it is known by heart, else 0
  } stim_row_t;

  // Directed words. The empty-message digest starts af1349b9f5f9a1a6.
  stim_row_t dir_rows [] = '{
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, 64'ha6a1f9f5b94913af},  // empty message
    '{64'h0000_0000_0000_0000, 4'd0, 1'b0, 64'd0},   // empty word, ignored
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1, 64'd0},   // one byte, upper bits junk
    '{64'h0123_4567_89AB_CDEF, 4'd8, 1'b0, 64'd0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 64'd0},  // count clipped to eight
    '{64'h0000_0000_0000_0000, 4'd0, 1'b0, 64'd0},
    '{64'hA5A5_5A5A_F00F_0FF0, 4'd9, 1'b1, 64'd0},
    '{64'h0000_0000_0000_0000, 4'd8, 1'b0, 64'd0},
    '{64'h8000_0000_0000_0001, 4'd3, 1'b0, 64'd0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, 64'd0},   // end mark with no new bytes
    '{64'h5555_5555_5555_5555, 4'd7, 1'b1, 64'd0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 4'd8, 1'b1, 64'd0}
  };

  initial begin
    int unsigned lens [];
    err_count        = 0;
    send_idle_pct    = 7;
    recv_idle_pct    = 49;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    data_bytes_i     = '0;
    byte_count_i     = '0;
    end_of_message_i = 1'b0;
    hasher_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      send_word(dir_rows[r].data, dir_rows[r].cnt, dir_rows[r].eom);
      // A known first word must match the first of the four just predicted.
      if (dir_rows[r].dig0 != 64'd0 &&
          pending_digest[$-3].digest_word != dir_rows[r].dig0) begin
        $error("digest_word expected %h actual %h", dir_rows[r].dig0,
               pending_digest[$-3].digest_word);
        err_count++;
      end
    end
    // Hold the sender until every digest is out.
    drain_digests();

    // Lengths around the block edge, then short random messages in three
    // idle phases.
    lens = '{63, 64, 65};
    foreach (lens[i]) send_message(lens[i]);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 49 : 0;
      recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 7 : 0;
      for (int m = 0; m < 4; m++) begin
        if ($urandom_range(5) == 0)
          send_word({$urandom, $urandom}, 4'd0, 1'b0);  // noise
        send_message($urandom_range(0, 40));
      end
    end
    send_idle_pct = 0;
    drain_digests();
    repeat (50) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
